FILE: src/vgu_pkg.sv
package vgu_pkg;

   localparam int COMP_WIDTH = 16;
   localparam int FRAC_BITS  = 12;
   localparam int TOL_WIDTH  = 15;
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(4);

   localparam logic [1:0] FUNC_NORMALIZE = 2'd0;
   localparam logic [1:0] FUNC_REFLECT   = 2'd1;
   localparam logic [1:0] FUNC_CROSS     = 2'd2;
   localparam logic [1:0] FUNC_EQUALS    = 2'd3;

   localparam int PROD_WIDTH  = 2 * COMP_WIDTH;
   // reflected vector magnitude stays below 2^(MAG_WIDTH-1)
   localparam int MAG_WIDTH   = 2 * COMP_WIDTH - FRAC_BITS + 1;
   localparam int VEC_WIDTH   = MAG_WIDTH + 1;
   // the largest normalized magnitude sits in [2^(NORM_WIDTH-1), 2^NORM_WIDTH)
   localparam int NORM_WIDTH  = 30;
   localparam int SHIFT_WIDTH = 5;
   localparam int SQ_WIDTH    = 2 * MAG_WIDTH;
   localparam int SUM_WIDTH   = SQ_WIDTH + 2;
   localparam int RAD_WIDTH   = 2 * NORM_WIDTH + 2;
   localparam int ROOT_WIDTH  = NORM_WIDTH + 1;
   localparam int QUO_WIDTH   = FRAC_BITS + 1;
   localparam int NUM_WIDTH   = NORM_WIDTH + FRAC_BITS + 1;
   localparam int CLAMP_WIDTH = 40;

   localparam logic signed [CLAMP_WIDTH-1:0] CLAMP_MAX =
      CLAMP_WIDTH'((64'sd1 <<< (COMP_WIDTH - 1)) - 64'sd1);
   localparam logic signed [CLAMP_WIDTH-1:0] CLAMP_MIN = -CLAMP_MAX - 1;

   typedef logic signed [COMP_WIDTH-1:0] comp_type;
   typedef logic signed [VEC_WIDTH-1:0]  vcomp_type;

   typedef struct packed {
      logic [1:0] func;
      comp_type   a_x;
      comp_type   a_y;
      comp_type   a_z;
      comp_type   b_x;
      comp_type   b_y;
      comp_type   b_z;
   } req_type;

   typedef struct packed {
      comp_type res_x;
      comp_type res_y;
      comp_type res_z;
      logic     is_equal;
      logic     zero_length;
      logic     saturated;
   } rsp_type;

   // results of the short paths, carried alongside the normalize path
   typedef struct packed {
      logic [1:0] func;
      comp_type   res_x;
      comp_type   res_y;
      comp_type   res_z;
      logic       is_equal;
      logic       saturated;
   } tag_type;

   typedef struct packed {
      vcomp_type x;
      vcomp_type y;
      vcomp_type z;
   } vec_type;

   typedef struct packed {
      logic [2:0]                 neg;
      logic                       zero;
      logic [2:0][NORM_WIDTH-1:0] w;
   } norm_type;

   typedef struct packed {
      logic [2:0] neg;
      logic       zero;
   } sign_type;

   typedef struct packed {
      logic     sat;
      comp_type val;
   } clamp_type;

   function automatic clamp_type clamp_comp(input logic signed [CLAMP_WIDTH-1:0] x);
      clamp_type r;
      if (x > CLAMP_MAX) begin
         r.sat = 1'b1;
         r.val = comp_type'(CLAMP_MAX);
      end else if (x < CLAMP_MIN) begin
         r.sat = 1'b1;
         r.val = comp_type'(CLAMP_MIN);
      end else begin
         r.sat = 1'b0;
         r.val = comp_type'(x);
      end
      return r;
   endfunction

endpackage

FILE: src/vgu_if.sv
interface vgu_req_if import vgu_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] func;
   comp_type   a_x;
   comp_type   a_y;
   comp_type   a_z;
   comp_type   b_x;
   comp_type   b_y;
   comp_type   b_z;

   modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, input ready);
   modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, output ready);
endinterface

interface vgu_rsp_if import vgu_pkg::*; ();
   logic     valid;
   logic     ready;
   comp_type res_x;
   comp_type res_y;
   comp_type res_z;
   logic     is_equal;
   logic     zero_length;
   logic     saturated;

   modport source (output valid, res_x, res_y, res_z, is_equal, zero_length, saturated,
                   input ready);
   modport sink   (input valid, res_x, res_y, res_z, is_equal, zero_length, saturated,
                   output ready);
endinterface

FILE: src/vgu_front.sv
// Products, dot/cross, tolerance compare, reflection. Four stages.
module vgu_front import vgu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  req_type              in_data,
   input  logic [TOL_WIDTH-1:0] tolerance,
   output logic                 out_valid,
   output tag_type              out_tag,
   output vec_type              out_vec
);

   localparam int DOT_SHIFT = FRAC_BITS - 2;
   localparam int DOT_HALF  = 1 << (DOT_SHIFT - 1);
   localparam int CRS_HALF  = 1 << (FRAC_BITS - 1);
   localparam int REF_SHIFT = FRAC_BITS - 1;
   localparam int REF_HALF  = 1 << (REF_SHIFT - 1);

   comp_type a_in [3];
   comp_type b_in [3];

   // stage 1
   logic signed [PROD_WIDTH-1:0] dp_in [3];
   logic signed [PROD_WIDTH-1:0] dp_ff [3];
   logic signed [PROD_WIDTH-1:0] cp_in [6];
   logic signed [PROD_WIDTH-1:0] cp_ff [6];
   logic signed [COMP_WIDTH:0]   diff [3];
   logic [COMP_WIDTH:0]          diff_mag [3];
   logic                         eq1_in, eq1_ff;
   comp_type                     a1_ff [3];
   comp_type                     b1_ff [3];
   logic [1:0]                   func1_ff;
   logic                         valid1_ff;

   // stage 2
   logic signed [PROD_WIDTH-1:0] dsum, dround;
   clamp_type                    dcl;
   logic signed [PROD_WIDTH+1:0] cdiff [3];
   logic signed [PROD_WIDTH+1:0] cround [3];
   clamp_type                    ccl [3];
   tag_type                      tag2_in, tag2_ff;
   comp_type                     d2_ff;
   comp_type                     a2_ff [3];
   comp_type                     b2_ff [3];
   logic                         valid2_ff;

   // stage 3
   logic signed [PROD_WIDTH-1:0] t_in [3];
   logic signed [PROD_WIDTH-1:0] t3_ff [3];
   comp_type                     a3_ff [3];
   tag_type                      tag3_ff;
   logic                         valid3_ff;

   // stage 4
   logic signed [PROD_WIDTH:0]   tround [3];
   vcomp_type                    v_in [3];
   vec_type                      v4_ff;
   tag_type                      tag4_ff;
   logic                         valid4_ff;

   always_comb begin
      a_in[0] = in_data.a_x;
      a_in[1] = in_data.a_y;
      a_in[2] = in_data.a_z;
      b_in[0] = in_data.b_x;
      b_in[1] = in_data.b_y;
      b_in[2] = in_data.b_z;
   end

   always_comb begin
      eq1_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         dp_in[i]    = a_in[i] * b_in[i];
         diff[i]     = (COMP_WIDTH+1)'(a_in[i]) - (COMP_WIDTH+1)'(b_in[i]);
         diff_mag[i] = diff[i][COMP_WIDTH] ? (COMP_WIDTH+1)'(-diff[i])
                                           : (COMP_WIDTH+1)'(diff[i]);
         if (diff_mag[i] > (COMP_WIDTH+1)'(tolerance)) begin
            eq1_in = 1'b0;
         end
      end
      cp_in[0] = a_in[1] * b_in[2];
      cp_in[1] = a_in[2] * b_in[1];
      cp_in[2] = a_in[2] * b_in[0];
      cp_in[3] = a_in[0] * b_in[2];
      cp_in[4] = a_in[0] * b_in[1];
      cp_in[5] = a_in[1] * b_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dp_ff    <= dp_in;
         cp_ff    <= cp_in;
         a1_ff    <= a_in;
         b1_ff    <= b_in;
         eq1_ff   <= eq1_in;
         func1_ff <= in_data.func;
      end
   end

   // dot product: floor each term by 4, round, clamp; cross: round, clamp
   always_comb begin
      dsum   = (dp_ff[0] >>> 2) + (dp_ff[1] >>> 2) + (dp_ff[2] >>> 2);
      dround = (dsum + DOT_HALF) >>> DOT_SHIFT;
      dcl    = clamp_comp(CLAMP_WIDTH'(dround));
      for (int i = 0; i < 3; i++) begin
         cdiff[i]  = cp_ff[2*i] - cp_ff[2*i+1];
         cround[i] = (cdiff[i] + CRS_HALF) >>> FRAC_BITS;
         ccl[i]    = clamp_comp(CLAMP_WIDTH'(cround[i]));
      end
      tag2_in.func      = func1_ff;
      tag2_in.res_x     = (func1_ff == FUNC_CROSS) ? ccl[0].val : '0;
      tag2_in.res_y     = (func1_ff == FUNC_CROSS) ? ccl[1].val : '0;
      tag2_in.res_z     = (func1_ff == FUNC_CROSS) ? ccl[2].val : '0;
      tag2_in.is_equal  = (func1_ff == FUNC_EQUALS) & eq1_ff;
      tag2_in.saturated = ((func1_ff == FUNC_REFLECT) & dcl.sat)
                        | ((func1_ff == FUNC_CROSS) & (ccl[0].sat | ccl[1].sat | ccl[2].sat));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag2_ff <= tag2_in;
         d2_ff   <= dcl.val;
         a2_ff   <= a1_ff;
         b2_ff   <= b1_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t_in[i] = d2_ff * b2_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_ff   <= t_in;
         a3_ff   <= a2_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // reflect: a - round(2 * dot * b)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tround[i] = (t3_ff[i] + REF_HALF) >>> REF_SHIFT;
         if (tag3_ff.func == FUNC_REFLECT) begin
            v_in[i] = VEC_WIDTH'(a3_ff[i]) - VEC_WIDTH'(tround[i]);
         end else begin
            v_in[i] = VEC_WIDTH'(a3_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v4_ff.x <= v_in[0];
         v4_ff.y <= v_in[1];
         v4_ff.z <= v_in[2];
         tag4_ff <= tag3_ff;
      end
   end

   assign out_valid = valid4_ff;
   assign out_tag   = tag4_ff;
   assign out_vec   = v4_ff;

endmodule

FILE: src/vgu_prep.sv
// Magnitudes, power-of-two scaling, sum of squares. Four stages.
module vgu_prep import vgu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  tag_type              in_tag,
   input  vec_type              in_vec,
   output logic                 out_valid,
   output tag_type              out_tag,
   output norm_type             out_norm,
   output logic [RAD_WIDTH-1:0] out_rad
);

   vcomp_type                v [3];
   vcomp_type                vneg [3];
   logic [MAG_WIDTH-1:0]     mag_in [3];
   logic [MAG_WIDTH-1:0]     mmax;
   logic [2:0]               neg_in;
   logic [SHIFT_WIDTH-1:0]   k_in;

   logic [MAG_WIDTH-1:0]     mag1_ff [3];
   logic [2:0]               neg1_ff;
   logic                     zero1_ff;
   logic [SHIFT_WIDTH-1:0]   k1_ff;
   tag_type                  tag1_ff;
   logic                     valid1_ff;

   logic [SQ_WIDTH-1:0]      sq_in [3];
   logic [SQ_WIDTH-1:0]      sq2_ff [3];
   logic [2:0][NORM_WIDTH-1:0] w_in;
   logic [2:0][NORM_WIDTH-1:0] w2_ff;
   logic [2:0]               neg2_ff;
   logic                     zero2_ff;
   logic [SHIFT_WIDTH-1:0]   k2_ff;
   tag_type                  tag2_ff;
   logic                     valid2_ff;

   logic [SUM_WIDTH-1:0]     sum3_ff;
   logic [2:0][NORM_WIDTH-1:0] w3_ff;
   logic [2:0]               neg3_ff;
   logic                     zero3_ff;
   logic [SHIFT_WIDTH-1:0]   k3_ff;
   tag_type                  tag3_ff;
   logic                     valid3_ff;

   logic [RAD_WIDTH-1:0]     rad4_ff;
   norm_type                 norm4_ff;
   tag_type                  tag4_ff;
   logic                     valid4_ff;

   // shift count puts the largest magnitude in [2^(NORM_WIDTH-1), 2^NORM_WIDTH)
   always_comb begin
      v[0] = in_vec.x;
      v[1] = in_vec.y;
      v[2] = in_vec.z;
      mmax = '0;
      for (int i = 0; i < 3; i++) begin
         neg_in[i] = v[i][VEC_WIDTH-1];
         vneg[i]   = -v[i];
         mag_in[i] = neg_in[i] ? MAG_WIDTH'(vneg[i]) : MAG_WIDTH'(v[i]);
         if (mag_in[i] > mmax) begin
            mmax = mag_in[i];
         end
      end
      k_in = '0;
      for (int b = 0; b < MAG_WIDTH; b++) begin
         if (mmax[b]) begin
            k_in = SHIFT_WIDTH'(NORM_WIDTH - 1 - b);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else if (en) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
         valid4_ff <= valid3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag_in;
         neg1_ff  <= neg_in;
         zero1_ff <= (mmax == '0);
         k1_ff    <= k_in;
         tag1_ff  <= in_tag;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = SQ_WIDTH'(mag1_ff[i]) * SQ_WIDTH'(mag1_ff[i]);
         w_in[i]  = NORM_WIDTH'(mag1_ff[i]) << k1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq2_ff   <= sq_in;
         w2_ff    <= w_in;
         neg2_ff  <= neg1_ff;
         zero2_ff <= zero1_ff;
         k2_ff    <= k1_ff;
         tag2_ff  <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum3_ff  <= SUM_WIDTH'(sq2_ff[0]) + SUM_WIDTH'(sq2_ff[1]) + SUM_WIDTH'(sq2_ff[2]);
         w3_ff    <= w2_ff;
         neg3_ff  <= neg2_ff;
         zero3_ff <= zero2_ff;
         k3_ff    <= k2_ff;
         tag3_ff  <= tag2_ff;
      end
   end

   // squares of the scaled vector: sum scaled by 4^k
   always_ff @(posedge clock) begin
      if (en) begin
         rad4_ff       <= RAD_WIDTH'(sum3_ff) << {k3_ff, 1'b0};
         norm4_ff.neg  <= neg3_ff;
         norm4_ff.zero <= zero3_ff;
         norm4_ff.w    <= w3_ff;
         tag4_ff       <= tag3_ff;
      end
   end

   assign out_valid = valid4_ff;
   assign out_tag   = tag4_ff;
   assign out_norm  = norm4_ff;
   assign out_rad   = rad4_ff;

endmodule

FILE: src/vgu_sqrt.sv
// Integer square root, one result bit per stage.
module vgu_sqrt import vgu_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  tag_type               in_tag,
   input  norm_type              in_norm,
   input  logic [RAD_WIDTH-1:0]  in_rad,
   output logic                  out_valid,
   output tag_type               out_tag,
   output norm_type              out_norm,
   output logic [ROOT_WIDTH-1:0] out_root
);

   logic                  valid_ff [ROOT_WIDTH];
   tag_type               tag_ff   [ROOT_WIDTH];
   norm_type              norm_ff  [ROOT_WIDTH];
   logic [RAD_WIDTH-1:0]  rem_ff   [ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_ff  [ROOT_WIDTH];

   for (genvar g = 0; g < ROOT_WIDTH; g++) begin : g_step
      localparam int J = ROOT_WIDTH - 1 - g;

      logic                  valid_prev;
      tag_type               tag_prev;
      norm_type              norm_prev;
      logic [RAD_WIDTH-1:0]  rem_prev;
      logic [ROOT_WIDTH-1:0] root_prev;
      logic [RAD_WIDTH-1:0]  trial;
      logic                  take;

      if (g == 0) begin : g_head
         assign valid_prev = in_valid;
         assign tag_prev   = in_tag;
         assign norm_prev  = in_norm;
         assign rem_prev   = in_rad;
         assign root_prev  = '0;
      end else begin : g_link
         assign valid_prev = valid_ff[g-1];
         assign tag_prev   = tag_ff[g-1];
         assign norm_prev  = norm_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign root_prev  = root_ff[g-1];
      end

      // (r + 2^J)^2 - r^2
      assign trial = (RAD_WIDTH'(root_prev) << (J + 1)) | (RAD_WIDTH'(1) << (2 * J));
      assign take  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g]  <= take ? rem_prev - trial : rem_prev;
            root_ff[g] <= take ? (root_prev | (ROOT_WIDTH'(1) << J)) : root_prev;
            tag_ff[g]  <= tag_prev;
            norm_ff[g] <= norm_prev;
         end
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign out_tag   = tag_ff[ROOT_WIDTH-1];
   assign out_norm  = norm_ff[ROOT_WIDTH-1];
   assign out_root  = root_ff[ROOT_WIDTH-1];

endmodule

FILE: src/vgu_div.sv
// Three restoring dividers sharing one divisor, one quotient bit per stage.
module vgu_div import vgu_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  tag_type                   in_tag,
   input  norm_type                  in_norm,
   input  logic [ROOT_WIDTH-1:0]     in_root,
   output logic                      out_valid,
   output tag_type                   out_tag,
   output sign_type                  out_sign,
   output logic [2:0][QUO_WIDTH-1:0] out_quo
);

   // numerator setup: (w << FRAC_BITS) + len / 2
   logic                      valid0_ff;
   tag_type                   tag0_ff;
   sign_type                  sign0_ff;
   logic [ROOT_WIDTH-1:0]     den0_ff;
   logic [2:0][NUM_WIDTH-1:0] num0_ff;

   logic                      valid_ff [QUO_WIDTH];
   tag_type                   tag_ff   [QUO_WIDTH];
   sign_type                  sign_ff  [QUO_WIDTH];
   logic [ROOT_WIDTH-1:0]     den_ff   [QUO_WIDTH];
   logic [2:0][NUM_WIDTH-1:0] rem_ff   [QUO_WIDTH];
   logic [2:0][QUO_WIDTH-1:0] quo_ff   [QUO_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         tag0_ff       <= in_tag;
         sign0_ff.neg  <= in_norm.neg;
         sign0_ff.zero <= in_norm.zero;
         den0_ff       <= in_root;
         for (int i = 0; i < 3; i++) begin
            num0_ff[i] <= (NUM_WIDTH'(in_norm.w[i]) << FRAC_BITS)
                        + NUM_WIDTH'(in_root >> 1);
         end
      end
   end

   for (genvar g = 0; g < QUO_WIDTH; g++) begin : g_step
      localparam int J = QUO_WIDTH - 1 - g;

      logic                      valid_prev;
      tag_type                   tag_prev;
      sign_type                  sign_prev;
      logic [ROOT_WIDTH-1:0]     den_prev;
      logic [2:0][NUM_WIDTH-1:0] rem_prev;
      logic [2:0][QUO_WIDTH-1:0] quo_prev;
      logic [NUM_WIDTH-1:0]      den_sh;

      if (g == 0) begin : g_head
         assign valid_prev = valid0_ff;
         assign tag_prev   = tag0_ff;
         assign sign_prev  = sign0_ff;
         assign den_prev   = den0_ff;
         assign rem_prev   = num0_ff;
         assign quo_prev   = '0;
      end else begin : g_link
         assign valid_prev = valid_ff[g-1];
         assign tag_prev   = tag_ff[g-1];
         assign sign_prev  = sign_ff[g-1];
         assign den_prev   = den_ff[g-1];
         assign rem_prev   = rem_ff[g-1];
         assign quo_prev   = quo_ff[g-1];
      end

      assign den_sh = NUM_WIDTH'(den_prev) << J;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[g] <= 1'b0;
         end else if (en) begin
            valid_ff[g] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[g]  <= tag_prev;
            sign_ff[g] <= sign_prev;
            den_ff[g]  <= den_prev;
            for (int i = 0; i < 3; i++) begin
               if (rem_prev[i] >= den_sh) begin
                  rem_ff[g][i] <= rem_prev[i] - den_sh;
                  quo_ff[g][i] <= quo_prev[i] | (QUO_WIDTH'(1) << J);
               end else begin
                  rem_ff[g][i] <= rem_prev[i];
                  quo_ff[g][i] <= quo_prev[i];
               end
            end
         end
      end
   end

   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign out_tag   = tag_ff[QUO_WIDTH-1];
   assign out_sign  = sign_ff[QUO_WIDTH-1];
   assign out_quo   = quo_ff[QUO_WIDTH-1];

endmodule

FILE: src/vector3_geometry_unit.sv
// Channel    Dir  Handshake          Payload
// req_chan   in   valid / ready      func, a_x, a_y, a_z, b_x, b_y, b_z
// rsp_chan   out  valid / ready      res_x, res_y, res_z, is_equal, zero_length, saturated
// csr        in   csr_wr_en          csr_wr_data (match tolerance)
//
// One request per cycle while the result buffer has room (req_chan.ready high).
// The pipeline runs through 8 front-end stages, the root stage (one bit per stage,
// 31 stages), the divider (one setup stage and 13 quotient stages) and the
// result buffer.
// Synchronous active-high reset clears valid bits, buffer count and tolerance (4).
// The pipeline moves as one; a two-entry result buffer keeps req_chan.ready up
// while one response waits, and it drops only when both entries are full.
module vector3_geometry_unit import vgu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [TOL_WIDTH-1:0] csr_wr_data,
   vgu_req_if.sink              req_chan,
   vgu_rsp_if.source            rsp_chan
);

   logic [TOL_WIDTH-1:0] tol_ff;

   logic     en;
   req_type  req_data;

   logic     fe_valid;
   tag_type  fe_tag;
   vec_type  fe_vec;

   logic                 pr_valid;
   tag_type              pr_tag;
   norm_type             pr_norm;
   logic [RAD_WIDTH-1:0] pr_rad;

   logic                  sq_valid;
   tag_type               sq_tag;
   norm_type              sq_norm;
   logic [ROOT_WIDTH-1:0] sq_root;

   logic                      dv_valid;
   tag_type                   dv_tag;
   sign_type                  dv_sign;
   logic [2:0][QUO_WIDTH-1:0] dv_quo;

   logic signed [QUO_WIDTH:0] sval [3];
   clamp_type                 ncl [3];
   rsp_type                   rsp_in;

   // result buffer
   rsp_type    fifo_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;
   rsp_type    head;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // whole pipeline advances while the buffer has room
   assign en             = (count_ff != 2'd2);
   assign req_chan.ready = en;

   always_comb begin
      req_data.func = req_chan.func;
      req_data.a_x  = req_chan.a_x;
      req_data.a_y  = req_chan.a_y;
      req_data.a_z  = req_chan.a_z;
      req_data.b_x  = req_chan.b_x;
      req_data.b_y  = req_chan.b_y;
      req_data.b_z  = req_chan.b_z;
   end

   vgu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_chan.valid),
      .in_data   (req_data),
      .tolerance (tol_ff),
      .out_valid (fe_valid),
      .out_tag   (fe_tag),
      .out_vec   (fe_vec)
   );

   vgu_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (fe_valid),
      .in_tag    (fe_tag),
      .in_vec    (fe_vec),
      .out_valid (pr_valid),
      .out_tag   (pr_tag),
      .out_norm  (pr_norm),
      .out_rad   (pr_rad)
   );

   vgu_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pr_valid),
      .in_tag    (pr_tag),
      .in_norm   (pr_norm),
      .in_rad    (pr_rad),
      .out_valid (sq_valid),
      .out_tag   (sq_tag),
      .out_norm  (sq_norm),
      .out_root  (sq_root)
   );

   vgu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_tag    (sq_tag),
      .in_norm   (sq_norm),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_sign  (dv_sign),
      .out_quo   (dv_quo)
   );

   // restore signs, clamp, pick the result for the operation
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sval[i] = dv_sign.neg[i] ? -$signed({1'b0, dv_quo[i]}) : $signed({1'b0, dv_quo[i]});
         ncl[i]  = clamp_comp(CLAMP_WIDTH'(sval[i]));
      end
      if ((dv_tag.func == FUNC_NORMALIZE) || (dv_tag.func == FUNC_REFLECT)) begin
         rsp_in.res_x       = dv_sign.zero ? '0 : ncl[0].val;
         rsp_in.res_y       = dv_sign.zero ? '0 : ncl[1].val;
         rsp_in.res_z       = dv_sign.zero ? '0 : ncl[2].val;
         rsp_in.is_equal    = 1'b0;
         rsp_in.zero_length = dv_sign.zero;
         rsp_in.saturated   = dv_tag.saturated
                            | (~dv_sign.zero & (ncl[0].sat | ncl[1].sat | ncl[2].sat));
      end else begin
         rsp_in.res_x       = dv_tag.res_x;
         rsp_in.res_y       = dv_tag.res_y;
         rsp_in.res_z       = dv_tag.res_z;
         rsp_in.is_equal    = dv_tag.is_equal;
         rsp_in.zero_length = 1'b0;
         rsp_in.saturated   = dv_tag.saturated;
      end
   end

   assign push = en & dv_valid;
   assign pop  = rsp_chan.valid & rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= rsp_in;
      end
   end

   assign head                 = fifo_ff[rd_ptr_ff];
   assign rsp_chan.valid       = (count_ff != 2'd0);
   assign rsp_chan.res_x       = head.res_x;
   assign rsp_chan.res_y       = head.res_y;
   assign rsp_chan.res_z       = head.res_z;
   assign rsp_chan.is_equal    = head.is_equal;
   assign rsp_chan.zero_length = head.zero_length;
   assign rsp_chan.saturated   = head.saturated;

endmodule

FILE: verif/vgu_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the tolerance register, predicts each response
// and compares it with what the unit returns.
module vgu_checker import vgu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [TOL_WIDTH-1:0] csr_wr_data,
   vgu_req_if                   req,
   vgu_rsp_if                   rsp,
   output int                   fail_count,
   output int                   outstanding
);

   rsp_type                expected_rsp[$];
   logic [TOL_WIDTH-1:0]   tolerance;

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   function automatic longint unsigned magnitude(input longint x);
      return (x < 0) ? longint'(-x) : longint'(x);
   endfunction

   // scaling shift, half rounds up
   function automatic longint round_shift(input longint x, input int s);
      if (s == 0) return x;
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_comp16(input longint x, inout bit sat);
      longint hi, lo;
      hi = (64'sd1 <<< (COMP_WIDTH - 1)) - 1;
      lo = -hi - 1;
      if (x > hi) begin
         sat = 1'b1;
         return hi;
      end
      if (x < lo) begin
         sat = 1'b1;
         return lo;
      end
      return x;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n    = n - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // unit vector in Q4.12; returns 1 for the zero vector
   function automatic bit unit_vector(input longint v[3], output longint o[3], inout bit sat);
      longint            w[3];
      longint unsigned   peak, sumsq, len, q;
      int                k;
      peak = 0;
      for (int i = 0; i < 3; i++)
         if (magnitude(v[i]) > peak) peak = magnitude(v[i]);
      if (peak == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b1;
      end
      k = 0;
      if (peak >= (64'd1 << 30)) begin
         while ((peak >> k) >= (64'd1 << 30)) k++;
         for (int i = 0; i < 3; i++) w[i] = v[i] >>> k;
      end else begin
         while ((peak << k) < (64'd1 << 29)) k++;
         for (int i = 0; i < 3; i++) w[i] = v[i] * (64'sd1 <<< k);
      end
      sumsq = 0;
      for (int i = 0; i < 3; i++) sumsq += magnitude(w[i]) * magnitude(w[i]);
      len = int_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
         q    = ((magnitude(w[i]) << FRAC_BITS) + len / 2) / len;
         o[i] = clamp_comp16((w[i] < 0) ? -longint'(q) : longint'(q), sat);
      end
      return 1'b0;
   endfunction

   function automatic rsp_type geometry_result(input req_type r, input logic [TOL_WIDTH-1:0] tol);
      rsp_type  res;
      longint   a[3], b[3], o[3], v[3], dot;
      bit       sat, zl, eq;
      a[0] = r.a_x; a[1] = r.a_y; a[2] = r.a_z;
      b[0] = r.b_x; b[1] = r.b_y; b[2] = r.b_z;
      for (int i = 0; i < 3; i++) o[i] = 0;
      sat = 1'b0;
      zl  = 1'b0;
      eq  = 1'b0;
      case (r.func)
         FUNC_NORMALIZE: begin
            zl = unit_vector(a, o, sat);
         end
         FUNC_REFLECT: begin
            dot = 0;
            for (int i = 0; i < 3; i++) dot += (a[i] * b[i]) >>> 2;
            dot = clamp_comp16(round_shift(dot, FRAC_BITS - 2), sat);
            for (int i = 0; i < 3; i++) v[i] = a[i] - round_shift(dot * b[i], FRAC_BITS - 1);
            zl = unit_vector(v, o, sat);
         end
         FUNC_CROSS: begin
            o[0] = clamp_comp16(round_shift(a[1] * b[2] - a[2] * b[1], FRAC_BITS), sat);
            o[1] = clamp_comp16(round_shift(a[2] * b[0] - a[0] * b[2], FRAC_BITS), sat);
            o[2] = clamp_comp16(round_shift(a[0] * b[1] - a[1] * b[0], FRAC_BITS), sat);
         end
         default: begin
            eq = 1'b1;
            for (int i = 0; i < 3; i++)
               if (magnitude(a[i] - b[i]) > longint'(tol)) eq = 1'b0;
         end
      endcase
      res.res_x       = comp_type'(o[0]);
      res.res_y       = comp_type'(o[1]);
      res.res_z       = comp_type'(o[2]);
      res.is_equal    = eq;
      res.zero_length = zl;
      res.saturated   = sat;
      return res;
   endfunction

   task automatic report(input string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      req_type  r;
      rsp_type  got, want;
      if (reset) begin
         tolerance = TOL_RESET;
      end else begin
         if (req.valid && req.ready) begin
            r = '{req.func, req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z};
            expected_rsp.push_back(geometry_result(r, tolerance));
         end
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.res_x, rsp.res_y, rsp.res_z, rsp.is_equal, rsp.zero_length,
                    rsp.saturated};
            if (expected_rsp.size() == 0) begin
               report("response with none expected");
            end else begin
               want = expected_rsp.pop_front();
               if (got.res_x !== want.res_x)
                  report($sformatf("res_x %0d, want %0d", got.res_x, want.res_x));
               if (got.res_y !== want.res_y)
                  report($sformatf("res_y %0d, want %0d", got.res_y, want.res_y));
               if (got.res_z !== want.res_z)
                  report($sformatf("res_z %0d, want %0d", got.res_z, want.res_z));
               if (got.is_equal !== want.is_equal)
                  report($sformatf("is_equal %b, want %b", got.is_equal, want.is_equal));
               if (got.zero_length !== want.zero_length)
                  report($sformatf("zero_length %b, want %b", got.zero_length,
                                   want.zero_length));
               if (got.saturated !== want.saturated)
                  report($sformatf("saturated %b, want %b", got.saturated, want.saturated));
            end
         end
         if (csr_wr_en) tolerance = csr_wr_data;
      end
      outstanding = expected_rsp.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the vector geometry unit; checking lives in vgu_checker.
module tb;
   import vgu_pkg::*;

   localparam int DRAIN_CYCLES  = 60;    // longer than the pipeline latency
   localparam int HOLD_CYCLES   = 300;   // long response back-pressure
   localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
   localparam int PHASE_ITEMS   = 200;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [TOL_WIDTH-1:0] csr_wr_data = '0;

   int                   fail_count;
   int                   outstanding;
   int                   quiet_cycles = 0;
   bit                   idle_on = 1'b1;   // random gaps on both sides
   bit                   hold_req = 1'b0;  // ask the receiver for a long hold-off
   int                   hold_cnt = 0;
   int                   tol_now = TOL_RESET;

   vgu_req_if req_chan ();
   vgu_rsp_if rsp_chan ();

   vector3_geometry_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   vgu_checker chk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   // Receiver: random ready, or a long counted hold-off on request.
   initial rsp_chan.ready = 1'b0;
   always @(negedge clock) begin
      if (hold_cnt > 0) begin
         rsp_chan.ready = 1'b0;
         hold_cnt--;
      end else if (hold_req) begin
         hold_req       = 1'b0;
         hold_cnt       = HOLD_CYCLES;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = !idle_on || ($urandom_range(99) >= 32);
      end
   end

   // Watchdog: no handshake on either channel for too long means a hang.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // One request: optional random gap, then hold it until it is taken.
   // Everything changes on the falling edge, away from the sampling edge.
   task automatic send_req(input logic [1:0] func, input int ax, ay, az, bx, by, bz);
      if (idle_on)
         while ($urandom_range(99) < 32) begin
            req_chan.valid = 1'b0;
            @(negedge clock);
         end
      req_chan.valid = 1'b1;
      req_chan.func  = func;
      req_chan.a_x   = comp_type'(ax);
      req_chan.a_y   = comp_type'(ay);
      req_chan.a_z   = comp_type'(az);
      req_chan.b_x   = comp_type'(bx);
      req_chan.b_y   = comp_type'(by);
      req_chan.b_z   = comp_type'(bz);
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Tolerance writes only with the pipe empty.
   task automatic drain_and_set_tol(input int tol);
      req_chan.valid = 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = TOL_WIDTH'(tol);
      @(negedge clock);
      csr_wr_en   = 1'b0;
      tol_now     = tol;
   endtask

   function automatic int pick_edge_value();
      case ($urandom_range(4))
         0: return 32767;
         1: return -32768;
         2: return 0;
         3: return 1;
         default: return -1;
      endcase
   endfunction

   // Random request mix: full range, small vectors, near-equal pairs, corner values.
   task automatic send_random_req();
      logic [1:0] f;
      int         v[6];
      int         kind;
      f    = 2'($urandom_range(3));
      kind = $urandom_range(9);
      for (int i = 0; i < 6; i++) begin
         if (kind <= 5)
            v[i] = int'($urandom_range(65535));
         else if (kind <= 7)
            v[i] = int'($urandom_range(8191)) - 4096;
         else if (kind == 8)
            v[i] = (i < 3) ? int'($urandom_range(65535))
                           : v[i-3] + int'($urandom_range(2 * tol_now + 2)) - tol_now - 1;
         else
            v[i] = pick_edge_value();
      end
      // near-equal pairs matter most for the equals compare
      if (kind == 8 && $urandom_range(1) == 0) f = FUNC_EQUALS;
      send_req(f, v[0], v[1], v[2], v[3], v[4], v[5]);
   endtask

   initial begin
      int tol_list[6];

      req_chan.valid = 1'b0;
      req_chan.func  = FUNC_NORMALIZE;
      req_chan.a_x   = '0;
      req_chan.a_y   = '0;
      req_chan.a_z   = '0;
      req_chan.b_x   = '0;
      req_chan.b_y   = '0;
      req_chan.b_z   = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part, reset tolerance of 4.
      send_req(FUNC_NORMALIZE, 0, 0, 0, 5, 5, 5);                 // zero length
      send_req(FUNC_NORMALIZE, 4096, 0, 0, 0, 0, 0);              // already unit
      send_req(FUNC_NORMALIZE, 32767, 32767, 32767, 0, 0, 0);
      send_req(FUNC_NORMALIZE, -32768, -32768, -32768, 0, 0, 0);
      send_req(FUNC_NORMALIZE, 1, 0, -1, 0, 0, 0);                // tiny vector
      send_req(FUNC_NORMALIZE, 0, -32768, 0, 0, 0, 0);
      send_req(FUNC_REFLECT, 0, 0, 0, 4096, 0, 0);                // reflect of zero
      send_req(FUNC_REFLECT, 4096, 0, 0, 4096, 0, 0);
      send_req(FUNC_REFLECT, 32767, 32767, 32767, 32767, 32767, 32767); // dot clamps high
      send_req(FUNC_REFLECT, -32768, -32768, -32768, 32767, 32767, 32767); // dot clamps low
      send_req(FUNC_REFLECT, 2896, 2896, 0, 0, 4096, 0);
      send_req(FUNC_REFLECT, 100, -200, 300, 0, 0, 0);            // zero normal
      send_req(FUNC_CROSS, 4096, 0, 0, 0, 4096, 0);
      send_req(FUNC_CROSS, 32767, -32768, 32767, -32768, 32767, -32768); // nearly antiparallel
      send_req(FUNC_CROSS, -32768, -32768, -32768, -32768, -32768, -32768);
      send_req(FUNC_CROSS, 1, 1, 1, -1, 1, -1);                   // rounding near zero
      send_req(FUNC_EQUALS, 10, 20, 30, 14, 16, 34);              // exactly at tolerance
      send_req(FUNC_EQUALS, 10, 20, 30, 15, 20, 30);              // one past
      send_req(FUNC_EQUALS, 32767, 0, 0, -32768, 0, 0);           // widest difference
      send_req(FUNC_EQUALS, 7, 7, 7, 7, 7, 7);

      // Tolerance extremes and values between, one phase of random requests each.
      tol_list = '{0, 32767, 1, int'($urandom_range(32767)), 4, int'($urandom_range(64))};
      for (int p = 0; p < 6; p++) begin
         drain_and_set_tol(tol_list[p]);
         if (p == 0) begin
            // exact-match edge with zero tolerance
            send_req(FUNC_EQUALS, 5, 5, 5, 5, 5, 5);
            send_req(FUNC_EQUALS, 5, 5, 5, 5, 5, 6);
         end
         if (p == 1) send_req(FUNC_EQUALS, 32767, -32768, 0, -32768, 32767, 0);
         idle_on = (p != 3);                 // phase 3 runs flat out on both sides
         if (p == 2) hold_req = 1'b1;       // sender keeps pushing into a blocked output
         for (int n = 0; n < PHASE_ITEMS; n++) send_random_req();
         idle_on = 1'b1;
      end

      req_chan.valid = 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
src/vgu_pkg.sv
src/vgu_if.sv
src/vgu_front.sv
src/vgu_prep.sv
src/vgu_sqrt.sv
src/vgu_div.sv
src/vector3_geometry_unit.sv
verif/vgu_checker.sv
verif/tb.sv
